[design/vdi_pkg.sv]
// shared types, constants and helpers of the vertex deduplication indexer
// no dependencies
`default_nettype none
package vdi_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = IDX_W + 1;
	localparam int KEY_W = 192;
	localparam int OUT_IDX_W = 12;
	localparam logic [CNT_W-1:0] TABLE_CNT = CNT_W'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

	typedef struct packed {
		logic        start_of_mesh;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
		logic [31:0] norm_x;
		logic [31:0] norm_y;
		logic [31:0] norm_z;
	} vdi_in_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] vertex_index;
		logic                 is_new;
		logic                 table_full;
	} vdi_out_t;

	// classified vertex passed from the front to the back
	typedef struct packed {
		logic             start_of_mesh;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] home_slot;
	} vdi_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SLOT,
		ST_ENTRY,
		ST_CHECK,
		ST_DONE
	} vdi_state_t;

	function automatic logic [OUT_IDX_W-1:0] vdi_out_index(input logic [IDX_W-1:0] idx);
		logic [IDX_W+OUT_IDX_W-1:0] wide;
		wide = {{OUT_IDX_W{1'b0}}, idx};
		return wide[OUT_IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

[design/vertex_dedup_indexer.sv]
// top level of the vertex deduplication indexer
// depends on vdi_pkg, vdi_front, vdi_back, vdi_out_q
//
// usage
//   input channel: a vertex beat (start flag plus six raw 32-bit words) is taken
//   when push is high and full is low; a two-beat queue holds vertices ahead of
//   the lookup engine
//   result channel: while empty is low the oldest result (index, new flag, full
//   flag) sits on result and leaves when pop is high; a two-beat queue sits here
//   lookup engine: takes one vertex at a time and walks the slots by linear
//   probing from the key's folded home slot; each probe reads the single read
//   port of the slot memory, then the owner/key memories at the entry found,
//   then checks the entry (ST_SLOT, ST_ENTRY, ST_CHECK); the result leaves
//   from ST_DONE
//   a full table answers a miss after walking all TABLE_ENTRIES slots
//   reset: queues empty, entry count zero, then a clearing pass over all TABLE_ENTRIES
//   (4096) slots zeroes the slot memory; vertices wait in the input queue meanwhile
//   stale slots are rejected by the entry count and an owner back-pointer
//   start_of_mesh drops the entry count to zero before that vertex is looked up
//   a stalled receiver fills the result queue, then the engine holds its result,
//   then the input queue fills and full rises; nothing is dropped
`default_nettype none
module vertex_dedup_indexer import vdi_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire vdi_in_t vertex,
	input  wire logic    push,
	output logic         full,
	output vdi_out_t     result,
	output logic         empty,
	input  wire logic    pop
);

	vdi_cmd_t cmd;
	logic     cmd_empty;
	logic     cmd_pop;
	vdi_out_t res;
	logic     res_push;
	logic     res_full;

	// classify and queue incoming vertices
	vdi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.vertex    (vertex),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop)
	);

	// probe, compare and insert
	vdi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res       (res),
		.res_push  (res_push),
		.res_full  (res_full)
	);

	// results waiting for the receiver
	vdi_out_q u_out_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.res_push (res_push),
		.res_full (res_full),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

	// a result is never both new and a full-table miss
	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(result.is_new && result.table_full))
		else $error("result flagged both new and table full");

	// a full-table miss carries index zero
	a_full_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.table_full) |-> (result.vertex_index == '0))
		else $error("table full result with nonzero index");

	// an accepted vertex beat lands in the front queue
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted vertex missing from front queue");

endmodule
`default_nettype wire

[design/vdi_front.sv]
// front: accepts vertices, folds the key into a home slot, two-entry queue
// depends on vdi_pkg
`default_nettype none
module vdi_front import vdi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vdi_in_t  vertex,
	input  wire logic     push,
	output logic          full,
	output vdi_cmd_t      cmd,
	output logic          cmd_empty,
	input  wire logic     cmd_pop
);

	vdi_cmd_t         fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic [KEY_W-1:0] key;
	logic [IDX_W-1:0] fold;
	logic [IDX_W-1:0] home;
	logic             do_push;
	logic             do_pop;

	assign key = {vertex.pos_x, vertex.pos_y, vertex.pos_z,
	              vertex.norm_x, vertex.norm_y, vertex.norm_z};

	// xor fold of the key
	always_comb begin
		fold = '0;
		for (int i = 0; i < KEY_W; i++) begin
			fold[i % IDX_W] = fold[i % IDX_W] ^ key[i];
		end
		home = (fold > LAST_SLOT) ? IDX_W'(fold - TABLE_CNT[IDX_W-1:0]) : fold;
	end

	assign full      = (fill_q == 2'd2);
	assign cmd_empty = (fill_q == 2'd0);
	assign cmd       = fifo_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_pop && !cmd_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= '{start_of_mesh: vertex.start_of_mesh, key: key,
			                      home_slot: home};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

[design/vdi_back.sv]
// back: linear-probe hash lookup and insert over the slot, owner and key memories
// depends on vdi_pkg
`default_nettype none
module vdi_back import vdi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vdi_cmd_t cmd,
	input  wire logic     cmd_empty,
	output logic          cmd_pop,
	output vdi_out_t      res,
	output logic          res_push,
	input  wire logic     res_full
);

	// slot -> entry index; entry -> owning slot; entry -> key
	logic [IDX_W-1:0] slot_mem  [TABLE_ENTRIES];
	logic [IDX_W-1:0] owner_mem [TABLE_ENTRIES];
	logic [KEY_W-1:0] key_mem   [TABLE_ENTRIES];

	vdi_state_t       state_q, state_nxt;
	logic [KEY_W-1:0] key_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] probes_q;
	logic [IDX_W-1:0] clr_q;
	logic [IDX_W-1:0] slot_rd_q;
	logic [IDX_W-1:0] ent_q;
	logic [IDX_W-1:0] owner_rd_q;
	logic [KEY_W-1:0] key_rd_q;
	vdi_out_t         res_q;

	logic valid_ent, hit, last_probe, do_insert;

	always_ff @(posedge clk) begin
		slot_rd_q  <= slot_mem[slot_q];
		owner_rd_q <= owner_mem[slot_rd_q];
		key_rd_q   <= key_mem[slot_rd_q];
		if (state_q == ST_CLEAR) begin
			slot_mem[clr_q] <= '0;
		end else if (do_insert) begin
			slot_mem[slot_q]                <= count_q[IDX_W-1:0];
			owner_mem[count_q[IDX_W-1:0]] <= slot_q;
			key_mem[count_q[IDX_W-1:0]]   <= key_q;
		end
	end

	// an entry is live only when it is below the count and points back at this slot
	assign valid_ent  = ({1'b0, ent_q} < count_q) && (owner_rd_q == slot_q);
	assign hit        = valid_ent && (key_rd_q == key_q);
	assign last_probe = (probes_q + CNT_W'(1)) == TABLE_CNT;
	assign do_insert  = (state_q == ST_CHECK) && !valid_ent;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == LAST_SLOT) state_nxt = ST_IDLE;
			ST_IDLE:  if (!cmd_empty) state_nxt = ST_SLOT;
			ST_SLOT:  state_nxt = ST_ENTRY;
			ST_ENTRY: state_nxt = ST_CHECK;
			ST_CHECK: begin
				if (hit || !valid_ent || last_probe) state_nxt = ST_DONE;
				else state_nxt = ST_SLOT;
			end
			ST_DONE:  if (!res_full) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			ST_IDLE: cmd_pop  = !cmd_empty;
			ST_DONE: res_push = !res_full;
			default: begin
				cmd_pop  = 1'b0;
				res_push = 1'b0;
			end
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			key_q <= cmd.key;
		end
		if (state_q == ST_ENTRY) begin
			ent_q <= slot_rd_q;
		end
		if (state_q == ST_CHECK) begin
			if (hit) begin
				res_q <= '{vertex_index: vdi_out_index(ent_q), is_new: 1'b0, table_full: 1'b0};
			end else if (!valid_ent) begin
				res_q <= '{vertex_index: vdi_out_index(count_q[IDX_W-1:0]), is_new: 1'b1,
				           table_full: 1'b0};
			end else begin
				res_q <= '{vertex_index: '0, is_new: 1'b0, table_full: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			count_q  <= '0;
			slot_q   <= '0;
			probes_q <= '0;
			clr_q    <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) clr_q <= clr_q + IDX_W'(1);
			if (state_q == ST_IDLE && !cmd_empty) begin
				slot_q   <= cmd.home_slot;
				probes_q <= '0;
				if (cmd.start_of_mesh) count_q <= '0;
			end
			if (state_q == ST_CHECK) begin
				if (do_insert) begin
					count_q <= count_q + CNT_W'(1);
				end else if (!hit) begin
					probes_q <= probes_q + CNT_W'(1);
					slot_q   <= (slot_q == LAST_SLOT) ? '0 : slot_q + IDX_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/vdi_out_q.sv]
// result queue of two beats in front of the result ports
// depends on vdi_pkg
`default_nettype none
module vdi_out_q import vdi_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire vdi_out_t res,
	input  wire logic     res_push,
	output logic          res_full,
	output vdi_out_t      result,
	output logic          empty,
	input  wire logic     pop
);

	vdi_out_t   fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign res_full = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign result   = fifo_q[rd_ptr_q];
	assign do_push  = res_push && !res_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) fifo_q[wr_ptr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			fill_q <= fill_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule
`default_nettype wire

[test/tb_vertex_dedup_indexer.sv]
// testbench of the vertex deduplication indexer: directed table, then random meshes
// depends on vdi_pkg and vertex_dedup_indexer
`timescale 1ns / 1ps
module tb_vertex_dedup_indexer;
	import vdi_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 632;

	logic     clk;
	logic     arst_n;
	vdi_in_t  vertex;
	logic     push;
	logic     full;
	vdi_out_t result;
	logic     empty;
	logic     pop;

	vertex_dedup_indexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.vertex(vertex),
		.push(push),
		.full(full),
		.result(result),
		.empty(empty),
		.pop(pop)
	);

	// shadow of the key table: key -> index, plus the number of valid keys
	int       shadow_index[bit [KEY_W-1:0]];
	int       shadow_count;
	vdi_in_t  mesh_keys[$];
	vdi_out_t pending_results[$];
	int       mismatches;
	int       cycle_count;
	bit       quiet;

	// directed rows: expectation typed in only where obvious
	typedef struct {
		vdi_in_t  v;
		bit       typed;
		vdi_out_t want;
	} row_t;

	row_t rows[$];

	initial begin
		clk = 1'b0;
	end
	always #2 clk = ~clk;

	function automatic void add_row(input vdi_in_t v, input bit typed, input vdi_out_t want);
		row_t r;
		r.v = v;
		r.typed = typed;
		r.want = want;
		rows.insert(rows.size(), r);
	endfunction

	function automatic vdi_out_t lookup_vertex(input vdi_in_t v);
		bit [KEY_W-1:0] key;
		vdi_out_t r;
		key = {v.pos_x, v.pos_y, v.pos_z, v.norm_x, v.norm_y, v.norm_z};
		r = '0;
		if (v.start_of_mesh) begin
			shadow_index.delete();
			shadow_count = 0;
		end
		if (shadow_index.exists(key)) begin
			r.vertex_index = OUT_IDX_W'(shadow_index[key]);
		end else if (shadow_count >= TABLE_ENTRIES) begin
			r.table_full = 1'b1;
		end else begin
			shadow_index[key] = shadow_count;
			r.vertex_index = OUT_IDX_W'(shadow_count);
			r.is_new = 1'b1;
			shadow_count++;
		end
		return r;
	endfunction

	// one input beat; the expectation is queued at the accepting edge
	task automatic send_vertex(input vdi_in_t v, input bit typed, input vdi_out_t want);
		vdi_out_t predicted;
		while (!quiet && $urandom_range(99) < 13) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		vertex <= v;
		do @(posedge clk); while (full);
		predicted = lookup_vertex(v);
		pending_results.insert(pending_results.size(), typed ? want : predicted);
		if (v.start_of_mesh)
			mesh_keys.delete();
		mesh_keys.insert(mesh_keys.size(), v);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;  // negative zero
			3: return 32'h7FC0_0000;  // quiet nan
			default: return $urandom;
		endcase
	endfunction

	function automatic vdi_in_t fresh_vertex(input bit sof);
		vdi_in_t v;
		v.start_of_mesh = sof;
		v.pos_x = pick_word();
		v.pos_y = pick_word();
		v.pos_z = pick_word();
		v.norm_x = pick_word();
		v.norm_y = pick_word();
		v.norm_z = pick_word();
		return v;
	endfunction

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// result side: check the oldest expectation, then roll the next pop
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %p", result);
			end else begin
				vdi_out_t want;
				want = pending_results.pop_front();
				if (result.vertex_index !== want.vertex_index || result.is_new !== want.is_new
						|| result.table_full !== want.table_full) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %p got %p", want, result);
				end
			end
		end
		pop <= quiet || ($urandom_range(99) >= 13);
	end

	// watchdog and a long stretch with no idling on either side
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		quiet <= (cycle_count > 5000 && cycle_count < 7000);
		if (cycle_count > CYCLE_LIMIT) begin
			$display("vertex_dedup_indexer regression: fail");
			$finish;
		end
	end

	initial begin
		vdi_in_t v;
		vdi_out_t z;
		int n;

		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		vertex = '0;
		mismatches = 0;
		cycle_count = 0;
		quiet = 1'b0;
		shadow_count = 0;
		z = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: zeros, ones, signed zeros, nan patterns, repeats, restarts
		v = '0;
		add_row(v, 1, '{12'd0, 1'b1, 1'b0});
		v = '1; v.start_of_mesh = 1'b0;
		add_row(v, 1, '{12'd1, 1'b1, 1'b0});
		v = '0;
		add_row(v, 1, '{12'd0, 1'b0, 1'b0});
		v.pos_x = 32'h8000_0000;
		add_row(v, 1, '{12'd2, 1'b1, 1'b0});
		v = '0; v.norm_z = 32'h8000_0000;
		add_row(v, 0, z);
		v = '0; v.pos_y = 32'h7FC0_0000; v.norm_y = 32'h7F80_0001;
		add_row(v, 0, z);
		add_row(v, 0, z);
		v = '1; v.start_of_mesh = 1'b0;
		add_row(v, 1, '{12'd1, 1'b0, 1'b0});
		v = '0; v.start_of_mesh = 1'b1; v.pos_z = 32'h3F80_0000;
		add_row(v, 1, '{12'd0, 1'b1, 1'b0});
		v = '0;
		add_row(v, 1, '{12'd1, 1'b1, 1'b0});
		v = '0; v.start_of_mesh = 1'b1;
		add_row(v, 1, '{12'd0, 1'b1, 1'b0});
		v.start_of_mesh = 1'b1;
		add_row(v, 1, '{12'd0, 1'b1, 1'b0});
		for (int i = 0; i < 6; i++)
			add_row(fresh_vertex(1'b0), 0, z);
		foreach (rows[i])
			send_vertex(rows[i].v, rows[i].typed, rows[i].want);

		// random meshes: mostly repeats of this mesh's keys, some new, rare restarts
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			n = $urandom_range(99);
			if (n < 3)
				v = fresh_vertex(1'b1);
			else if (n < 60 && mesh_keys.size() != 0) begin
				v = mesh_keys[$urandom_range(mesh_keys.size() - 1)];
				v.start_of_mesh = 1'b0;
			end else
				v = fresh_vertex(1'b0);
			send_vertex(v, 0, z);
		end
		drain();

		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("vertex_dedup_indexer regression: pass");
		end else begin
			$display("vertex_dedup_indexer regression: fail");
		end
		$finish;
	end

endmodule
